FILE: src/tbbc_pkg.sv
// types and constants shared by the two-buffer block cache policy
`default_nettype none
package tbbc_pkg;

  localparam logic [7:0] EMPTY_TAG   = 8'hFF;
  localparam logic [9:0] BLOCK_BYTES = 10'd512;
  localparam logic       BUF_READ    = 1'b0;
  localparam logic       BUF_WRITE   = 1'b1;

  // per-file buffer state
  typedef struct packed {
    logic [7:0] rd_tag;
    logic       rd_dirty;
    logic [7:0] wr_tag;
  } tbbc_entry_t;

  typedef struct packed {
    logic       address_error;
    logic       buffer_select;
    logic [8:0] byte_offset;
    logic [9:0] bytes_left;
    logic       writeback_needed;
    logic       writeback_buffer;
    logic [7:0] writeback_block;
    logic       fetch_needed;
    logic [7:0] fetch_block;
  } tbbc_result_t;

endpackage
`default_nettype wire

FILE: src/tbbc_if.sv
// valid/ready channel interfaces for access items and result items
`default_nettype none
interface tbbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] file_id;
  logic [15:0] line_address;
  logic       access_is_write;

  modport source (output valid, output file_id, output line_address,
                  output access_is_write, input ready);
  modport sink (input valid, input file_id, input line_address,
                input access_is_write, output ready);
endinterface

interface tbbc_out_if;
  logic       valid;
  logic       ready;
  logic       address_error;
  logic       buffer_select;
  logic [8:0] byte_offset;
  logic [9:0] bytes_left;
  logic       writeback_needed;
  logic       writeback_buffer;
  logic [7:0] writeback_block;
  logic       fetch_needed;
  logic [7:0] fetch_block;

  modport source (output valid, output address_error, output buffer_select,
                  output byte_offset, output bytes_left, output writeback_needed,
                  output writeback_buffer, output writeback_block,
                  output fetch_needed, output fetch_block, input ready);
  modport sink (input valid, input address_error, input buffer_select,
                input byte_offset, input bytes_left, input writeback_needed,
                input writeback_buffer, input writeback_block,
                input fetch_needed, input fetch_block, output ready);
endinterface
`default_nettype wire

FILE: src/tbbc_lookup.sv
// tag compare and buffer policy decision for one access
`default_nettype none
module tbbc_lookup
  import tbbc_pkg::*;
(
  input  wire logic         file_ok,
  input  wire logic [15:0]  line_address,
  input  wire logic         access_is_write,
  input  wire tbbc_entry_t  entry_cur,
  output tbbc_result_t      result,
  output tbbc_entry_t       entry_nxt,
  output logic              update
);

  logic [7:0] blk;
  logic [8:0] off;

  assign blk = line_address[15:8];
  assign off = {line_address[7:1], 2'b00};

  always_comb begin
    result    = '0;
    entry_nxt = entry_cur;
    update    = 1'b0;
    if (!file_ok || blk == EMPTY_TAG) begin
      result.address_error = 1'b1;
    end else begin
      update             = 1'b1;
      result.byte_offset = off;
      result.bytes_left  = BLOCK_BYTES - {1'b0, off};
      if (blk == entry_cur.rd_tag) begin
        entry_nxt.rd_dirty   = entry_cur.rd_dirty | access_is_write;
        result.buffer_select = BUF_READ;
      end else if (blk == entry_cur.wr_tag) begin
        result.buffer_select = BUF_WRITE;
      end else if (!access_is_write) begin
        // read miss: flush dirty read buffer, then fetch into it
        if (entry_cur.rd_dirty) begin
          result.writeback_needed = 1'b1;
          result.writeback_buffer = BUF_READ;
          result.writeback_block  = entry_cur.rd_tag;
        end
        entry_nxt.rd_dirty   = 1'b0;
        entry_nxt.rd_tag     = blk;
        result.fetch_needed  = 1'b1;
        result.fetch_block   = blk;
        result.buffer_select = BUF_READ;
      end else begin
        // write miss: flush write buffer if it holds a block, then retag
        if (entry_cur.wr_tag != EMPTY_TAG) begin
          result.writeback_needed = 1'b1;
          result.writeback_buffer = BUF_WRITE;
          result.writeback_block  = entry_cur.wr_tag;
        end
        entry_nxt.wr_tag     = blk;
        result.buffer_select = BUF_WRITE;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/two_buffer_block_cache_policy.sv
// Two-buffer block cache policy, top level. Each file context holds a read
// buffer tag with a dirty flag and a write buffer tag; an access item gives
// back one result telling which buffer holds the bytes, the byte offset and
// bytes left in the 512-byte block, and any write-back or fetch needed first.
// Blocks numbered 255 and files at or above NUM_FILES come back as address
// errors with no state change. An item passes an input register and a result
// register, one item per cycle sustained while out_ch.ready holds no stall, since
// the per-file state is read and updated in the single stage between them.
`default_nettype none
module two_buffer_block_cache_policy
  import tbbc_pkg::*;
#(
  parameter int NUM_FILES = 4
) (
  input wire logic   clk,
  input wire logic   rst_n,
  tbbc_in_if.sink    in_ch,
  tbbc_out_if.source out_ch
);

  localparam int IDX_W = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam logic [4:0] NUM_FILES_W = 5'(NUM_FILES);

  logic         s1_valid_r;
  logic [1:0]   s1_file_id_r;
  logic [15:0]  s1_line_address_r;
  logic         s1_write_r;
  logic         out_valid_r;
  tbbc_result_t res_r;
  tbbc_entry_t  entry_r [NUM_FILES];

  logic                   advance;
  logic                   s1_fire;
  logic                   file_ok;
  logic [IDX_W+1:0]       fid_ext;
  logic [IDX_W-1:0]       idx;
  tbbc_entry_t            entry_cur;
  tbbc_entry_t            entry_nxt;
  tbbc_result_t           result;
  logic                   update;

  assign advance      = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;

  assign file_ok   = {3'b000, s1_file_id_r} < NUM_FILES_W;
  assign fid_ext   = {{IDX_W{1'b0}}, s1_file_id_r};
  assign idx       = fid_ext[IDX_W-1:0];
  // out-of-range files never touch the array
  assign entry_cur = file_ok ? entry_r[idx] : '{rd_tag: EMPTY_TAG, rd_dirty: 1'b0,
                                                wr_tag: EMPTY_TAG};

  tbbc_lookup u_lookup (
    .file_ok         (file_ok),
    .line_address    (s1_line_address_r),
    .access_is_write (s1_write_r),
    .entry_cur       (entry_cur),
    .result          (result),
    .entry_nxt       (entry_nxt),
    .update          (update)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_FILES; i++) begin
        entry_r[i] <= '{rd_tag: EMPTY_TAG, rd_dirty: 1'b0, wr_tag: EMPTY_TAG};
      end
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire && update) begin
        entry_r[idx] <= entry_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_file_id_r      <= in_ch.file_id;
      s1_line_address_r <= in_ch.line_address;
      s1_write_r        <= in_ch.access_is_write;
    end
    if (s1_fire) begin
      res_r <= result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.address_error    = res_r.address_error;
  assign out_ch.buffer_select    = res_r.buffer_select;
  assign out_ch.byte_offset      = res_r.byte_offset;
  assign out_ch.bytes_left       = res_r.bytes_left;
  assign out_ch.writeback_needed = res_r.writeback_needed;
  assign out_ch.writeback_buffer = res_r.writeback_buffer;
  assign out_ch.writeback_block  = res_r.writeback_block;
  assign out_ch.fetch_needed     = res_r.fetch_needed;
  assign out_ch.fetch_block      = res_r.fetch_block;

endmodule
`default_nettype wire
